// File: hw/rtl/sldf_pkg.sv
// Shared types, codes and constants of the sync/length/checksum deframer.
package sldf_pkg;

    // Sync words as seen little-endian: previous byte low, current byte high.
    localparam logic [15:0] SYNC_CHECKED = 16'hC1AF;
    localparam logic [15:0] SYNC_PLAIN   = 16'hC1AE;

    // Register reset values.
    localparam logic [7:0] TIMEOUT_RESET    = 8'd200;
    localparam logic [7:0] HUNT_LIMIT_RESET = 8'd25;

    // Configuration register indexes.
    localparam logic CFG_BYTE_TIMEOUT = 1'b0;
    localparam logic CFG_HUNT_LIMIT   = 1'b1;

    // Input item kinds carried on the slave tuser bit.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // Master tdata width: 35 field bits padded to whole bytes.
    localparam int M_TDATA_W = 40;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADSUM  = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_NOSYNC  = 2'd3
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  frame_type;
        logic [7:0]  frame_length;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        checksummed;
        t_status     status;
        logic        last;
    } t_result;

    // Results produced by one accepted item: up to two, first one first.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic t_result make_result(
        input t_kind      kind,
        input logic [7:0] ftype,
        input logic [7:0] flen,
        input logic [7:0] pbyte,
        input logic [7:0] pidx,
        input logic       cks,
        input t_status    st,
        input logic       lst
    );
        t_result r;
        r.kind          = kind;
        r.frame_type    = ftype;
        r.frame_length  = flen;
        r.payload_byte  = pbyte;
        r.payload_index = pidx;
        r.checksummed   = cks;
        r.status        = st;
        r.last          = lst;
        return r;
    endfunction

endpackage

// File: hw/rtl/sldf_parser.sv
// Frame parser: hunt, header, payload and timeout state with its result logic.
module sldf_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_addr,
    input  logic [7:0]     i_cfg_wdata,
    input  logic           i_accept,
    input  logic           i_action,
    input  logic [7:0]     i_byte,
    output sldf_pkg::t_push o_push
);
    import sldf_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_TYPE   = 3'd1,
        PH_LEN    = 3'd2,
        PH_SUM_LO = 3'd3,
        PH_SUM_HI = 3'd4,
        PH_DATA   = 3'd5
    } t_phase;

    logic [7:0]  r_timeout, r_limit;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_prev, n_prev;
    logic        r_mode, n_mode;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_rsum, n_rsum;
    logic [15:0] r_run, n_run;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_idle, n_idle;
    logic [7:0]  r_att, n_att;

    logic [7:0]  idle_inc, att_inc, cnt_inc;
    logic [15:0] word, sum_add, rsum_full;
    logic        hunting, do_fail;
    t_status     end_st;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_limit   <= HUNT_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_addr == CFG_BYTE_TIMEOUT) begin
                r_timeout <= i_cfg_wdata;
            end else begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // Saturating counters and helper sums.
    assign idle_inc  = (r_idle == 8'hFF) ? r_idle : r_idle + 8'd1;
    assign att_inc   = (r_att == 8'hFF) ? r_att : r_att + 8'd1;
    assign cnt_inc   = r_cnt + 8'd1;
    assign word      = {i_byte, r_prev};
    assign sum_add   = r_run + {8'd0, i_byte};
    assign rsum_full = {i_byte, r_rsum[7:0]};
    assign hunting   = !(r_phase == PH_TYPE || r_phase == PH_LEN || r_phase == PH_SUM_LO ||
                         r_phase == PH_SUM_HI || r_phase == PH_DATA);

    // Next state and results of the item being accepted.
    always_comb begin
        n_phase = r_phase;
        n_prev  = r_prev;
        n_mode  = r_mode;
        n_type  = r_type;
        n_len   = r_len;
        n_rsum  = r_rsum;
        n_run   = r_run;
        n_cnt   = r_cnt;
        n_idle  = r_idle;
        n_att   = r_att;
        do_fail = 1'b0;
        end_st  = ST_OK;
        o_push  = '0;

        if (i_accept) begin
            if (i_action == ACT_TICK) begin
                n_idle = idle_inc;
                if (idle_inc >= r_timeout) begin
                    n_idle = 8'd0;
                    if (hunting) begin
                        do_fail = 1'b1;
                    end else begin
                        o_push.count = 2'd1;
                        o_push.first = make_result(KIND_ERR, r_type, r_len, 8'd0, 8'd0,
                                                   r_mode, ST_TIMEOUT, 1'b1);
                        n_phase = PH_HUNT;
                        n_prev  = 8'd0;
                        n_att   = 8'd0;
                    end
                end
            end else begin
                n_idle = 8'd0;
                case (r_phase)
                    PH_TYPE: begin
                        n_type  = i_byte;
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        n_len = i_byte;
                        if (r_mode) begin
                            n_phase = PH_SUM_LO;
                        end else if (i_byte == 8'd0) begin
                            o_push.count = 2'd1;
                            o_push.first = make_result(KIND_END, r_type, i_byte, 8'd0, 8'd0,
                                                       r_mode, ST_OK, 1'b1);
                            n_phase = PH_HUNT;
                            n_prev  = 8'd0;
                            n_att   = 8'd0;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                    PH_SUM_LO: begin
                        n_rsum  = {8'd0, i_byte};
                        n_phase = PH_SUM_HI;
                    end
                    PH_SUM_HI: begin
                        n_rsum = rsum_full;
                        if (r_len == 8'd0) begin
                            // Empty payload: the running sum is still zero.
                            end_st = (r_mode && rsum_full != 16'd0) ? ST_BADSUM : ST_OK;
                            o_push.count = 2'd1;
                            o_push.first = make_result(KIND_END, r_type, r_len, 8'd0, 8'd0,
                                                       r_mode, end_st, 1'b1);
                            n_phase = PH_HUNT;
                            n_prev  = 8'd0;
                            n_att   = 8'd0;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        o_push.count = 2'd1;
                        o_push.first = make_result(KIND_DATA, r_type, r_len, i_byte, r_cnt,
                                                   r_mode, ST_OK, 1'b0);
                        n_run = sum_add;
                        n_cnt = cnt_inc;
                        if (cnt_inc >= r_len) begin
                            end_st = (r_mode && sum_add != r_rsum) ? ST_BADSUM : ST_OK;
                            o_push.count  = 2'd2;
                            o_push.second = make_result(KIND_END, r_type, r_len, 8'd0, 8'd0,
                                                        r_mode, end_st, 1'b1);
                            n_phase = PH_HUNT;
                            n_prev  = 8'd0;
                            n_att   = 8'd0;
                        end
                    end
                    default: begin
                        // Hunting: look for a sync word over the last two bytes.
                        n_prev = i_byte;
                        if (word == SYNC_CHECKED || word == SYNC_PLAIN) begin
                            n_mode  = (word == SYNC_CHECKED);
                            n_type  = 8'd0;
                            n_len   = 8'd0;
                            n_rsum  = 16'd0;
                            n_run   = 16'd0;
                            n_cnt   = 8'd0;
                            n_att   = 8'd0;
                            n_phase = PH_TYPE;
                        end else begin
                            n_phase = PH_HUNT;
                            do_fail = 1'b1;
                        end
                    end
                endcase
            end

            // One failed hunt attempt; the limit gives a no-sync error.
            if (do_fail) begin
                if (att_inc >= r_limit) begin
                    o_push.count = 2'd1;
                    o_push.first = make_result(KIND_ERR, 8'd0, 8'd0, 8'd0, 8'd0,
                                               1'b0, ST_NOSYNC, 1'b1);
                    n_phase = PH_HUNT;
                    n_prev  = 8'd0;
                    n_att   = 8'd0;
                end else begin
                    n_att = att_inc;
                end
            end
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_prev  <= 8'd0;
            r_mode  <= 1'b0;
            r_type  <= 8'd0;
            r_len   <= 8'd0;
            r_rsum  <= 16'd0;
            r_run   <= 16'd0;
            r_cnt   <= 8'd0;
            r_idle  <= 8'd0;
            r_att   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_mode  <= n_mode;
            r_type  <= n_type;
            r_len   <= n_len;
            r_rsum  <= n_rsum;
            r_run   <= n_run;
            r_cnt   <= n_cnt;
            r_idle  <= n_idle;
            r_att   <= n_att;
        end
    end

    // A pair of results is always a payload byte followed by its frame end.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.count == 2'd2 |->
            o_push.first.kind == KIND_DATA && o_push.second.kind == KIND_END)
        else $error("two results that are not payload then frame end");

    // Any closing result sends the parser back to hunting.
    a_close_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count != 2'd0 && (o_push.first.last || o_push.second.last))
            |=> r_phase == PH_HUNT)
        else $error("parser not hunting after a frame end or error");

    // Hunt attempts only accumulate while hunting.
    a_att_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_HUNT |-> r_att == 8'd0)
        else $error("hunt attempts nonzero inside a frame");

endmodule

// File: hw/rtl/sync_length_checksum_deframer_core.sv
// Top level of the deframer: stream ports, parser and result queue.
//
// One item enters per clock: a received byte or a time tick. The parser
// updates its state in the cycle the item is accepted and writes zero, one
// or two results into a four-entry result queue; the master side drains one
// result per cycle from the queue head while m_axis_tready is high. Output
// s_axis_tready is high while at least two queue entries are free, so items
// flow at one per cycle as long as results are taken at least as fast as
// they are made. An item that carries the final payload byte of a frame
// makes two results (byte and frame end), which the queue absorbs.
// Configuration writes take effect at the next clock and are meant for idle
// periods. No clearing pass follows reset.
module sync_length_checksum_deframer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_addr,
    input  logic [7:0]                     i_cfg_wdata,
    // Slave stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
    input  logic                           s_axis_tuser,  // [0] action
    // Master stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] frame_type, [15:8] frame_length, [23:16] payload_byte,
    // [31:24] payload_index, [32] checksummed, [34:33] status, [39:35] zero
    output logic [sldf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]                     m_axis_tuser,  // [1:0] result_kind
    output logic                           m_axis_tlast
);
    import sldf_pkg::*;

    t_push                 push;
    t_result               r_mem [FIFO_DEPTH];
    t_result               head;
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  in_accept, pop;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign m_axis_tvalid = (r_count != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;

    sldf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (in_accept),
        .i_action    (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .o_push      (push)
    );

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= push.first;
        end
        if (push.count == 2'd2) begin
            r_mem[r_wr_ptr + FIFO_PTR_W'(1)] <= push.second;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(push.count);
            r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(pop);
            r_count  <= r_count + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
        end
    end

    // Master side fields from the queue head.
    assign head         = r_mem[r_rd_ptr];
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;
    assign m_axis_tdata = {5'd0, head.status, head.checksummed, head.payload_index,
                           head.payload_byte, head.frame_length, head.frame_type};

    // The queue never overfills.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // A pop with nothing pushed lowers the fill count by one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && push.count == 2'd0) |=> r_count == $past(r_count) - FIFO_CNT_W'(1))
        else $error("result queue count wrong after pop");

    // Results come only from accepted items.
    a_push_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.count != 2'd0 |-> in_accept)
        else $error("result written without an accepted item");

endmodule

// File: bench/tb_sync_length_checksum_deframer_core.sv
// Self-checking testbench for the sync/length/checksum deframer core.
module tb_sync_length_checksum_deframer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sldf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LEN,
        PH_SUM_LO,
        PH_SUM_HI,
        PH_DATA
    } parse_phase_e;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_op_e;

    // One line of the directed plan: an item, or a pair of register values.
    typedef struct {
        row_op_e    op;
        logic       act;
        logic [7:0] data;
        bit         typed;
        t_result    want;
        logic [7:0] set_timeout;
        logic [7:0] set_hunt;
    } plan_row_t;

    // Error result when no sync word turns up within the hunt limit.
    localparam t_result NOSYNC_ABORT = '{kind: KIND_ERR, frame_type: 8'h00,
        frame_length: 8'h00, payload_byte: 8'h00, payload_index: 8'h00,
        checksummed: 1'b0, status: ST_NOSYNC, last: 1'b1};

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic                   i_cfg_addr    = CFG_BYTE_TIMEOUT;
    logic [7:0]             i_cfg_wdata   = 8'h00;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = 8'h00;  // [7:0] rx_byte
    logic                   s_axis_tuser  = ACT_BYTE;  // [0] action
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [7:0] frame_type, [15:8] frame_length, [23:16] payload_byte,
    // [31:24] payload_index, [32] checksummed, [34:33] status, [39:35] zero
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [1:0]             m_axis_tuser;  // [1:0] result_kind
    logic                   m_axis_tlast;

    // Deframer state as the testbench tracks it.
    parse_phase_e phase;
    logic [7:0]   prev_rx;
    logic         sum_mode;
    logic [7:0]   frame_type_r;
    logic [7:0]   frame_len_r;
    logic [15:0]  sum_announced;
    logic [15:0]  sum_payload;
    logic [7:0]   payload_idx;
    logic [7:0]   idle_ticks;
    logic [7:0]   hunt_misses;
    logic [7:0]   lim_timeout;
    logic [7:0]   lim_hunt;

    t_result      expected_q [$];
    plan_row_t    plan [$];
    int           errors      = 0;
    int           items_sent  = 0;
    int           stall_left  = 0;
    int unsigned  cycles      = 0;
    bit           src_idle_en = 1'b1;
    bit           sink_idle_en = 1'b1;

    sync_length_checksum_deframer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic string describe(t_result r);
        return $sformatf("kind %0d type %02h len %02h byte %02h idx %0d cks %0d st %0d last %0d",
                         r.kind, r.frame_type, r.frame_length, r.payload_byte,
                         r.payload_index, r.checksummed, r.status, r.last);
    endfunction

    function automatic void flag_mismatch(string msg);
        errors++;
        if (errors <= 10) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function automatic void expect_result(t_kind kind, logic [7:0] ftype, logic [7:0] flen,
                                          logic [7:0] pbyte, logic [7:0] pidx, logic cks,
                                          t_status st, logic lst);
        expected_q.push_back('{kind: kind, frame_type: ftype, frame_length: flen,
                               payload_byte: pbyte, payload_index: pidx,
                               checksummed: cks, status: st, last: lst});
    endfunction

    function automatic void reset_tracker();
        phase         = PH_HUNT;
        prev_rx       = '0;
        sum_mode      = 1'b0;
        frame_type_r  = '0;
        frame_len_r   = '0;
        sum_announced = '0;
        sum_payload   = '0;
        payload_idx   = '0;
        idle_ticks    = '0;
        hunt_misses   = '0;
        lim_timeout   = TIMEOUT_RESET;
        lim_hunt      = HUNT_LIMIT_RESET;
    endfunction

    function automatic void restart_hunt();
        phase       = PH_HUNT;
        prev_rx     = '0;
        hunt_misses = '0;
    endfunction

    // A failed hunt attempt; too many of them give the no-sync error.
    function automatic void note_hunt_miss();
        if (hunt_misses != 8'hFF) begin
            hunt_misses++;
        end
        if (hunt_misses >= lim_hunt) begin
            expected_q.push_back(NOSYNC_ABORT);
            restart_hunt();
        end
    endfunction

    function automatic void close_frame();
        t_status st;
        st = (sum_mode && sum_payload != sum_announced) ? ST_BADSUM : ST_OK;
        expect_result(KIND_END, frame_type_r, frame_len_r, 8'h00, 8'h00, sum_mode, st, 1'b1);
        restart_hunt();
    endfunction

    // Advance the tracked state by one accepted item and queue its results.
    function automatic void track_item(logic act, logic [7:0] b);
        logic [15:0] word;
        if (act == ACT_TICK) begin
            if (idle_ticks != 8'hFF) begin
                idle_ticks++;
            end
            if (idle_ticks >= lim_timeout) begin
                idle_ticks = '0;
                if (phase == PH_HUNT) begin
                    note_hunt_miss();
                end else begin
                    expect_result(KIND_ERR, frame_type_r, frame_len_r, 8'h00, 8'h00,
                                  sum_mode, ST_TIMEOUT, 1'b1);
                    restart_hunt();
                end
            end
        end else begin
            idle_ticks = '0;
            case (phase)
                PH_HUNT: begin
                    word    = {b, prev_rx};
                    prev_rx = b;
                    if (word == SYNC_CHECKED || word == SYNC_PLAIN) begin
                        sum_mode      = (word == SYNC_CHECKED);
                        frame_type_r  = '0;
                        frame_len_r   = '0;
                        sum_announced = '0;
                        sum_payload   = '0;
                        payload_idx   = '0;
                        hunt_misses   = '0;
                        phase         = PH_TYPE;
                    end else begin
                        note_hunt_miss();
                    end
                end
                PH_TYPE: begin
                    frame_type_r = b;
                    phase        = PH_LEN;
                end
                PH_LEN: begin
                    frame_len_r = b;
                    if (sum_mode) begin
                        phase = PH_SUM_LO;
                    end else if (b == 8'h00) begin
                        close_frame();
                    end else begin
                        phase = PH_DATA;
                    end
                end
                PH_SUM_LO: begin
                    sum_announced = {8'h00, b};
                    phase         = PH_SUM_HI;
                end
                PH_SUM_HI: begin
                    sum_announced[15:8] = b;
                    if (frame_len_r == 8'h00) begin
                        close_frame();
                    end else begin
                        phase = PH_DATA;
                    end
                end
                default: begin
                    expect_result(KIND_DATA, frame_type_r, frame_len_r, b, payload_idx,
                                  sum_mode, ST_OK, 1'b0);
                    sum_payload += {8'h00, b};
                    payload_idx++;
                    if (payload_idx >= frame_len_r) begin
                        close_frame();
                    end
                end
            endcase
        end
    endfunction

    // Compare one taken result with the oldest expectation.
    function automatic void check_result();
        t_result got;
        t_result want;
        got.kind          = t_kind'(m_axis_tuser);
        got.frame_type    = m_axis_tdata[7:0];
        got.frame_length  = m_axis_tdata[15:8];
        got.payload_byte  = m_axis_tdata[23:16];
        got.payload_index = m_axis_tdata[31:24];
        got.checksummed   = m_axis_tdata[32];
        got.status        = t_status'(m_axis_tdata[34:33]);
        got.last          = m_axis_tlast;
        if (expected_q.size() == 0) begin
            flag_mismatch({"result with nothing expected: ", describe(got)});
        end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
                flag_mismatch({"expected ", describe(want), " got ", describe(got)});
            end
        end
    endfunction

    function automatic plan_row_t byte_row(logic [7:0] b);
        plan_row_t row;
        row.op          = ROW_ITEM;
        row.act         = ACT_BYTE;
        row.data        = b;
        row.typed       = 1'b0;
        row.want        = '0;
        row.set_timeout = '0;
        row.set_hunt    = '0;
        return row;
    endfunction

    function automatic plan_row_t tick_row();
        plan_row_t row;
        row     = byte_row(8'hA5);
        row.act = ACT_TICK;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(logic [7:0] timeout_ticks, logic [7:0] hunt_limit);
        plan_row_t row;
        row             = byte_row(8'h00);
        row.op          = ROW_CFG;
        row.set_timeout = timeout_ticks;
        row.set_hunt    = hunt_limit;
        return row;
    endfunction

    function automatic plan_row_t with_result(plan_row_t row, t_result want);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    // Directed plan: zero-length checked frame, one-byte plain frame, bad
    // checksum, timeout inside a frame, hunt exhaustion, and zero registers.
    function automatic void build_plan();
        plan.push_back(byte_row(8'hAF));
        plan.push_back(byte_row(8'hC1));
        plan.push_back(byte_row(8'hFF));
        plan.push_back(byte_row(8'h00));
        plan.push_back(byte_row(8'h00));
        plan.push_back(with_result(byte_row(8'h00), '{kind: KIND_END, frame_type: 8'hFF,
            frame_length: 8'h00, payload_byte: 8'h00, payload_index: 8'h00,
            checksummed: 1'b1, status: ST_OK, last: 1'b1}));
        plan.push_back(byte_row(8'hAE));
        plan.push_back(byte_row(8'hC1));
        plan.push_back(byte_row(8'h00));
        plan.push_back(byte_row(8'h01));
        plan.push_back(byte_row(8'hFF));
        plan.push_back(byte_row(8'hAF));
        plan.push_back(byte_row(8'hC1));
        plan.push_back(byte_row(8'h5A));
        plan.push_back(byte_row(8'h02));
        plan.push_back(byte_row(8'hFF));
        plan.push_back(byte_row(8'h00));
        plan.push_back(byte_row(8'h80));
        plan.push_back(byte_row(8'h80));
        plan.push_back(cfg_row(8'd1, 8'd2));
        plan.push_back(byte_row(8'hAE));
        plan.push_back(byte_row(8'hC1));
        plan.push_back(with_result(tick_row(), '{kind: KIND_ERR, frame_type: 8'h00,
            frame_length: 8'h00, payload_byte: 8'h00, payload_index: 8'h00,
            checksummed: 1'b0, status: ST_TIMEOUT, last: 1'b1}));
        plan.push_back(byte_row(8'h00));
        plan.push_back(with_result(byte_row(8'h37), NOSYNC_ABORT));
        plan.push_back(cfg_row(8'd0, 8'd0));
        plan.push_back(with_result(tick_row(), NOSYNC_ABORT));
        plan.push_back(with_result(byte_row(8'hFF), NOSYNC_ABORT));
    endfunction

    // Offer one item, wait for it to be taken, then update the tracked state.
    task automatic send_item(input logic act, input logic [7:0] b,
                             input bit typed = 1'b0, input t_result want = '0);
        int depth;
        if (src_idle_en && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        depth = expected_q.size();
        track_item(act, b);
        if (typed) begin
            while (expected_q.size() > depth) void'(expected_q.pop_back());
            expected_q.push_back(want);
        end
        items_sent++;
    endtask

    // A byte, sometimes preceded by a few ticks of line silence.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 3)) send_item(ACT_TICK, rand_byte());
        end
        send_item(ACT_BYTE, b);
    endtask

    task automatic send_frame(input int len);
        logic [7:0]  body [$];
        logic [15:0] sum;
        logic        checked;
        checked = 1'($urandom_range(0, 1));
        sum     = '0;
        repeat (len) begin
            body.push_back(rand_byte());
            sum += {8'h00, body[body.size() - 1]};
        end
        // Corrupt the announced checksum now and then.
        if ($urandom_range(0, 3) == 0) begin
            sum = 16'($urandom_range(0, 65535));
        end
        send_byte(checked ? SYNC_CHECKED[7:0] : SYNC_PLAIN[7:0]);
        send_byte(SYNC_CHECKED[15:8]);
        send_byte(rand_byte());
        send_byte(8'(len));
        if (checked) begin
            send_byte(sum[7:0]);
            send_byte(sum[15:8]);
        end
        foreach (body[i]) begin
            send_byte(body[i]);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Both registers are written back to back once the block has gone quiet.
    task automatic write_config(input logic [7:0] timeout_ticks, input logic [7:0] hunt_limit);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= CFG_BYTE_TIMEOUT;
        i_cfg_wdata <= timeout_ticks;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_HUNT_LIMIT;
        i_cfg_wdata <= hunt_limit;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        lim_timeout = timeout_ticks;
        lim_hunt    = hunt_limit;
    endtask

    // Random traffic under one register setting: mostly well-formed frames,
    // with noise, tick bursts and frames cut short mixed in.
    task automatic run_phase(input logic [7:0] timeout_ticks, input logic [7:0] hunt_limit,
                             input int n_items, input int n_long, input bit idle);
        int first;
        int pick;
        int n;
        bit paused;
        write_config(timeout_ticks, hunt_limit);
        src_idle_en  = idle;
        sink_idle_en = idle;
        first        = items_sent;
        paused       = 1'b0;
        repeat (n_long) send_frame(255);
        while (items_sent - first < n_items) begin
            if (idle && $urandom_range(0, 29) == 0) begin
                src_idle_en  = 1'($urandom_range(0, 1));
                sink_idle_en = 1'($urandom_range(0, 1));
            end
            // Halfway through, hold the sender until every result is out.
            if (!paused && items_sent - first >= n_items / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
                send_frame(n);
            end else if (pick < 80) begin
                n = ($urandom_range(0, 19) == 0) ? 30 : $urandom_range(1, 5);
                repeat (n) send_item(ACT_BYTE, rand_byte());
            end else if (pick < 92) begin
                n = (lim_timeout <= 8'd40 && $urandom_range(0, 1) == 1) ?
                    int'(lim_timeout) : $urandom_range(1, 3);
                repeat ((n == 0) ? 1 : n) send_item(ACT_TICK, rand_byte());
            end else begin
                // Header cut short; times out if lim_timeout <= 40.
                send_byte(($urandom_range(0, 1) == 1) ? SYNC_CHECKED[7:0] : SYNC_PLAIN[7:0]);
                send_byte(SYNC_CHECKED[15:8]);
                send_byte(rand_byte());
                repeat ($urandom_range(0, 3)) send_byte(rand_byte());
                if (lim_timeout <= 8'd40) begin
                    n = (lim_timeout == 8'd0) ? 1 : int'(lim_timeout);
                    repeat (n) send_item(ACT_TICK, rand_byte());
                end
            end
        end
    endtask

    // Result sink: checks taken results and stalls in random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_result();
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        reset_tracker();
        build_plan();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].op == ROW_CFG) begin
                write_config(plan[r].set_timeout, plan[r].set_hunt);
            end else begin
                send_item(plan[r].act, plan[r].data, plan[r].typed, plan[r].want);
            end
        end

        run_phase(TIMEOUT_RESET, HUNT_LIMIT_RESET, 130, 0, 1'b1);
        run_phase(8'd255, 8'd255, 300, 1, 1'b1);
        run_phase(8'd1, 8'd1, 60, 0, 1'b1);
        run_phase(8'($urandom_range(2, 12)), 8'($urandom_range(2, 8)), 80, 0, 1'b1);
        run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 90, 0, 1'b0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            flag_mismatch($sformatf("%0d expected results never came", expected_q.size()));
        end
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
